/* hw/rtl/pte_pkg.sv */
// shared types and constants for the periodic timer event scheduler
// no dependencies; imported by pte_ctrl, pte_dp and the top level
`default_nettype none

package pte_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int MAX_FIRES  = 64;

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(MAX_FIRES + 1);

	localparam logic [1:0] OP_ADVANCE    = 2'd0;
	localparam logic [1:0] OP_SET_TIMER  = 2'd1;
	localparam logic [1:0] OP_CLEAR_TIME = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] delta_ticks;
		logic [2:0]  timer_index;
		logic        enable_value;
		logic [31:0] period;
	} pte_in_t;

	typedef struct packed {
		logic [2:0]  fired_timer;
		logic [63:0] fire_time;
		logic        last;
		logic        truncated;
	} pte_out_t;

	typedef struct packed {
		logic adv_load;
		logic set_timer;
		logic clr_time;
		logic scan_clear;
		logic scan_step;
		logic fire;
		logic emit;
		logic reload;
		logic finish;
	} pte_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic found;
		logic cnt_full;
		logic have_pend;
	} pte_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/pte_ctrl.sv */
// controller state machine: sequences scans, firings and reloads of an advance
// depends on pte_pkg
`default_nettype none

module pte_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        opcode,
	input  wire pte_pkg::pte_stat_t stat,
	output pte_pkg::pte_cmd_t      cmd,
	output logic                   busy
);
	import pte_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_RELOAD
	} state_t;

	state_t state_q;
	logic   accept;
	logic   do_fire;

	assign accept  = start && !busy;
	assign do_fire = stat.found && !stat.cnt_full;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.adv_load   = (opcode == OP_ADVANCE);
					cmd.scan_clear = (opcode == OP_ADVANCE);
					cmd.set_timer  = (opcode == OP_SET_TIMER);
					cmd.clr_time   = (opcode == OP_CLEAR_TIME);
				end
			end
			ST_SCAN: cmd.scan_step = 1'b1;
			ST_DECIDE: begin
				cmd.emit   = stat.have_pend;
				cmd.fire   = do_fire;
				cmd.finish = !do_fire;
			end
			ST_RELOAD: begin
				cmd.reload     = 1'b1;
				cmd.scan_clear = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && opcode == OP_ADVANCE) begin
						state_q <= ST_SCAN;
						busy    <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (stat.scan_last)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (do_fire) begin
						state_q <= ST_RELOAD;
					end else begin
						state_q <= ST_IDLE;
						busy    <= 1'b0;
					end
				end
				ST_RELOAD: state_q <= ST_SCAN;
				default: begin
					state_q <= ST_IDLE;
					busy    <= 1'b0;
				end
			endcase
		end
	end

	busy_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy == (state_q != ST_IDLE))
		else $error("busy out of step with state");

	reload_follows_fire: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RELOAD |-> $past(cmd.fire))
		else $error("reload without a firing");

	decide_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE |-> $past(state_q == ST_SCAN && stat.scan_last))
		else $error("decision before the scan ended");

endmodule

`default_nettype wire

/* hw/rtl/pte_dp.sv */
// datapath: tick time, timer table, earliest-expiry scan and result register
// depends on pte_pkg
`default_nettype none

module pte_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pte_pkg::pte_in_t   item,
	input  wire pte_pkg::pte_cmd_t  cmd,
	output pte_pkg::pte_stat_t      stat,
	output pte_pkg::pte_out_t       result,
	output logic                    result_strobe
);
	import pte_pkg::*;

	logic [63:0]      time_q;
	logic [63:0]      target_q;
	logic             en_q [NUM_TIMERS];
	logic [31:0]      per_q [NUM_TIMERS];
	logic [63:0]      exp_q [NUM_TIMERS];

	logic [IDX_W-1:0] scan_idx_q;
	logic             best_found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [63:0]      best_exp_q;
	logic [31:0]      best_per_q;

	logic [IDX_W-1:0] pend_idx_q;
	logic [63:0]      pend_time_q;
	logic             have_pend_q;
	logic [CNT_W-1:0] cnt_q;

	logic [IDX_W-1:0] widx;
	logic             in_range;
	logic [31:0]      new_per;
	logic             cand;
	logic             better;
	logic             cnt_full;

	assign widx     = IDX_W'(item.timer_index);
	assign in_range = (32'(item.timer_index) < 32'(NUM_TIMERS));
	assign new_per  = (item.period == 32'd0) ? 32'd1 : item.period;
	assign cand     = en_q[scan_idx_q] && (exp_q[scan_idx_q] < target_q);
	assign better   = !best_found_q || (exp_q[scan_idx_q] < best_exp_q);
	assign cnt_full = (cnt_q == CNT_W'(MAX_FIRES));

	assign stat.scan_last = (scan_idx_q == IDX_W'(NUM_TIMERS - 1));
	assign stat.found     = best_found_q;
	assign stat.cnt_full  = cnt_full;
	assign stat.have_pend = have_pend_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q        <= '0;
			scan_idx_q    <= '0;
			best_found_q  <= 1'b0;
			have_pend_q   <= 1'b0;
			cnt_q         <= '0;
			result_strobe <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++)
				en_q[i] <= 1'b0;
		end else begin
			result_strobe <= cmd.emit;
			if (cmd.set_timer && in_range)
				en_q[widx] <= item.enable_value;
			if (cmd.clr_time)
				time_q <= '0;
			if (cmd.finish)
				time_q <= target_q;
			if (cmd.adv_load) begin
				have_pend_q <= 1'b0;
				cnt_q       <= '0;
			end
			if (cmd.scan_clear) begin
				scan_idx_q   <= '0;
				best_found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (!stat.scan_last)
					scan_idx_q <= scan_idx_q + 1'b1;
				if (cand && better)
					best_found_q <= 1'b1;
			end
			if (cmd.fire)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.reload)
				have_pend_q <= 1'b1;
		end
	end

	// timer table and payload
	always_ff @(posedge clk) begin
		if (cmd.set_timer && in_range) begin
			per_q[widx] <= new_per;
			if (item.enable_value && !en_q[widx])
				exp_q[widx] <= time_q + {32'd0, new_per};
		end
		if (cmd.reload)
			exp_q[best_idx_q] <= best_exp_q + {32'd0, best_per_q};
		if (cmd.adv_load)
			target_q <= time_q + {32'd0, item.delta_ticks};
		if (cmd.scan_step && cand && better) begin
			best_idx_q <= scan_idx_q;
			best_exp_q <= exp_q[scan_idx_q];
			best_per_q <= per_q[scan_idx_q];
		end
		if (cmd.fire) begin
			pend_idx_q  <= best_idx_q;
			pend_time_q <= best_exp_q;
		end
		if (cmd.emit) begin
			result.fired_timer <= 3'(pend_idx_q);
			result.fire_time   <= pend_time_q;
			result.last        <= !best_found_q || cnt_full;
			result.truncated   <= best_found_q && cnt_full;
		end
	end

	strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(cmd.emit))
		else $error("result strobe without an emit");

	truncated_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.truncated |-> result.last)
		else $error("truncated flag on a non-final result");

	count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_FIRES))
		else $error("firing count beyond cap");

	fire_needs_winner: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fire |-> best_found_q && !cnt_full)
		else $error("firing without a due timer");

endmodule

`default_nettype wire

/* hw/rtl/periodic_timer_event_scheduler_top.sv */
// top level of the periodic timer event scheduler
// depends on pte_pkg, pte_ctrl and pte_dp
//
// usage:
//   item is taken at a rising edge with start high and busy low. opcode
//   set-timer, clear-time and the unused code finish as they are taken and
//   busy stays low, so another item may follow in the next cycle.
//   an advance raises busy. the datapath walks the timer table one entry a
//   cycle looking for the earliest due expiry; each firing then passes a
//   decision state, a reload state and another full walk. each firing is a
//   transfer on result, shown for one cycle with result_strobe high; a
//   result goes out only once the next walk has shown whether another
//   firing follows, so last and truncated are exact. the final result
//   appears in the cycle busy falls.
//   the receiver cannot stall: results are not held and must be taken.
//   reset clears time, disables all timers and returns to idle; periods
//   and expiries hold no value until written.
`default_nettype none

module periodic_timer_event_scheduler_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire pte_pkg::pte_in_t  item,
	output logic                   result_strobe,
	output pte_pkg::pte_out_t      result
);
	import pte_pkg::*;

	pte_cmd_t  cmd;
	pte_stat_t stat;

	pte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (item.opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	pte_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.cmd           (cmd),
		.stat          (stat),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench for periodic_timer_event_scheduler_top
// predicts every timer firing from the accepted commands and checks each result transfer
// depends on pte_pkg and the scheduler rtl only

module tb_top;
	import pte_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 312;
	localparam int CALM_TAIL    = 60;
	localparam int DRAIN_CYCLES = (MAX_FIRES + 1) * (NUM_TIMERS + 1) + MAX_FIRES + 16;

	class timer_fire_checker;
		bit [63:0] now_tick;
		bit        enabled [NUM_TIMERS];
		bit [31:0] reload  [NUM_TIMERS];
		bit [63:0] expiry  [NUM_TIMERS];
		pte_out_t  expected_firings[$];
		int        mismatches;

		function new();
			now_tick = '0;
			mismatches = 0;
			foreach (enabled[i]) begin
				enabled[i] = 1'b0;
				reload[i] = '0;
				expiry[i] = '0;
			end
		endfunction

		function int earliest_due(bit [63:0] target);
			int best;
			best = -1;
			for (int i = 0; i < NUM_TIMERS; i++)
				if (enabled[i] && expiry[i] < target && (best < 0 || expiry[i] < expiry[best]))
					best = i;
			return best;
		endfunction

		function void note_item(pte_in_t it);
			bit [63:0] target;
			bit [31:0] per;
			int        fires;
			int        t;
			pte_out_t  r;
			case (it.opcode)
			OP_SET_TIMER: begin
				per = (it.period == 0) ? 32'd1 : it.period;
				reload[it.timer_index] = per;
				if (it.enable_value && !enabled[it.timer_index])
					expiry[it.timer_index] = now_tick + per;
				enabled[it.timer_index] = it.enable_value;
			end
			OP_CLEAR_TIME: now_tick = '0;
			OP_ADVANCE: begin
				target = now_tick + it.delta_ticks;
				fires = 0;
				t = earliest_due(target);
				while (t >= 0 && fires < MAX_FIRES) begin
					now_tick = expiry[t];
					expiry[t] = expiry[t] + reload[t];
					fires++;
					r.fired_timer = 3'(t);
					r.fire_time = now_tick;
					t = earliest_due(target);
					r.last = (t < 0) || (fires == MAX_FIRES);
					r.truncated = (t >= 0) && (fires == MAX_FIRES);
					expected_firings.push_back(r);
				end
				now_tick = target;
			end
			default: ;
			endcase
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_firing(pte_out_t got);
			pte_out_t want;
			if (expected_firings.size() == 0) begin
				flag($sformatf("unexpected transfer timer %0d time %0d last %0d truncated %0d",
					got.fired_timer, got.fire_time, got.last, got.truncated));
				return;
			end
			want = expected_firings.pop_front();
			if (got.fired_timer !== want.fired_timer || got.fire_time !== want.fire_time ||
					got.last !== want.last || got.truncated !== want.truncated)
				flag($sformatf("timer %0d/%0d time %0d/%0d last %0d/%0d truncated %0d/%0d (got/exp)",
					got.fired_timer, want.fired_timer, got.fire_time, want.fire_time,
					got.last, want.last, got.truncated, want.truncated));
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     result_strobe;
	pte_in_t  item;
	pte_out_t result;

	timer_fire_checker fc;

	periodic_timer_event_scheduler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_strobe(result_strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("periodic_timer_event_scheduler_top test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_strobe)
			fc.check_firing(result);
	end

	function automatic pte_in_t make_item(logic [1:0] op, logic [31:0] delta, logic [2:0] idx,
			logic en, logic [31:0] per);
		pte_in_t it;
		it.opcode = op;
		it.delta_ticks = delta;
		it.timer_index = idx;
		it.enable_value = en;
		it.period = per;
		return it;
	endfunction

	function automatic logic [31:0] pick_span();
		logic [31:0] v;
		case ($urandom_range(0, 9))
		0: v = '0;
		7: v = $urandom_range(25, 600);
		8: v = $urandom;
		9: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
		default: v = $urandom_range(1, 24);
		endcase
		return v;
	endfunction

	function automatic pte_in_t random_item();
		pte_in_t it;
		int kind;
		it = make_item(OP_UNUSED, $urandom, 3'($urandom_range(0, 7)),
			1'($urandom_range(0, 1)), $urandom);
		kind = $urandom_range(0, 99);
		if (kind < 34) begin
			it.opcode = OP_SET_TIMER;
			it.enable_value = ($urandom_range(0, 3) != 0);
			it.period = pick_span();
		end else if (kind < 86) begin
			it.opcode = OP_ADVANCE;
			it.delta_ticks = pick_span();
		end else if (kind < 93) begin
			it.opcode = OP_CLEAR_TIME;
		end
		return it;
	endfunction

	task automatic send_item(input pte_in_t it);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		fc.note_item(it);
		@(negedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic maybe_idle(input bit allowed);
		if (allowed && $urandom_range(0, 3) == 0)
			pause_sender($urandom_range(1, 11));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (fc.expected_firings.size() != 0 || busy)
			@(negedge clk);
	endtask

	initial begin
		pte_in_t directed[$];
		pte_in_t it;
		int      sent;
		bit      idling_on;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		fc = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table, extremes of delta, clear and the unused code
		directed.push_back(make_item(OP_ADVANCE, 32'd0, 3'd7, 1'b1, 32'hFFFF_FFFF));
		directed.push_back(make_item(OP_ADVANCE, 32'hFFFF_FFFF, 3'd0, 1'b0, 32'd0));
		directed.push_back(make_item(OP_CLEAR_TIME, 32'hFFFF_FFFF, 3'd7, 1'b1, 32'hFFFF_FFFF));
		directed.push_back(make_item(OP_UNUSED, 32'hFFFF_FFFF, 3'd7, 1'b1, 32'hFFFF_FFFF));
		// zero period, max period, equal expiries
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd0, 1'b1, 32'd0));
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd7, 1'b1, 32'hFFFF_FFFF));
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd3, 1'b1, 32'd5));
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd4, 1'b1, 32'd5));
		directed.push_back(make_item(OP_ADVANCE, 32'd6, 3'd0, 1'b0, 32'd0));
		// re-enable keeps expiry, disable keeps expiry
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd3, 1'b1, 32'd2));
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd4, 1'b0, 32'd9));
		// firing cap, then deferred firings on a zero advance
		directed.push_back(make_item(OP_ADVANCE, 32'd100, 3'd0, 1'b0, 32'd0));
		directed.push_back(make_item(OP_ADVANCE, 32'd0, 3'd0, 1'b0, 32'd0));
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd0, 1'b0, 32'd1));
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd3, 1'b0, 32'd1));
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd7, 1'b0, 32'd0));
		// exactly the cap with nothing left due
		directed.push_back(make_item(OP_CLEAR_TIME, 32'd0, 3'd0, 1'b0, 32'd0));
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd1, 1'b1, 32'd1));
		directed.push_back(make_item(OP_ADVANCE, 32'd65, 3'd0, 1'b0, 32'd0));
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd1, 1'b0, 32'd1));
		// expiry equal to the target does not fire, then a tie fires in index order
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd4, 1'b1, 32'd3));
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd2, 1'b1, 32'd3));
		directed.push_back(make_item(OP_ADVANCE, 32'd3, 3'd0, 1'b0, 32'd0));
		directed.push_back(make_item(OP_ADVANCE, 32'd1, 3'd0, 1'b0, 32'd0));
		directed.push_back(make_item(OP_SET_TIMER, 32'd0, 3'd2, 1'b0, 32'd3));

		foreach (directed[i]) begin
			send_item(directed[i]);
			maybe_idle(1'b1);
		end
		wait_drained();

		sent = 0;
		idling_on = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 40 == 0)
				idling_on = ($urandom_range(0, 2) != 0);
			if (sent == RANDOM_ITEMS / 2)
				wait_drained();
			it = random_item();
			send_item(it);
			if (it.opcode != OP_UNUSED)
				sent++;
			maybe_idle(idling_on && sent < RANDOM_ITEMS - CALM_TAIL);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fc.expected_firings.size() != 0)
			fc.flag($sformatf("%0d firings never came out", fc.expected_firings.size()));
		if (fc.mismatches == 0)
			$display("periodic_timer_event_scheduler_top test passed");
		else
			$display("periodic_timer_event_scheduler_top test failed");
		$finish;
	end

endmodule
